// ===== rtl/core/mrpt_pkg.sv =====
package mrpt_pkg;

    localparam int WIT_BITS   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_BITS   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WITNESS_COUNT = 3'd0;

    localparam logic [WIT_BITS-1:0] RESET_WITNESS [0:6] = '{
        32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17
    };

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,     // latch candidate, start p-1 split
        OP_SHIFT,    // one step of the d/e split
        OP_REDUCE,   // witness mod p, one bit per cycle
        OP_MUL,      // take a multiply result, or set up the power with start_pow
        OP_INIT_MUL  // arm a multiply
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] mul_sel;  // 0: r*=f, 1: f*=f, 2: x*=x
        logic       start_pow;
    } dp_cmd_t;

    localparam logic [1:0] MUL_RF = 2'd0;
    localparam logic [1:0] MUL_FF = 2'd1;
    localparam logic [1:0] MUL_XX = 2'd2;

endpackage

// ===== rtl/core/miller_rabin_prime_test_top.sv =====
// Deterministic Miller-Rabin test of one candidate at a time against up to
// MAX_WITNESSES configured bases. One shared shift-and-add modular multiplier
// forms every product; even values, 0 and 1 finish without the witness loop.
// A new item is taken only after the previous result has been moved to the
// output register.
module miller_rabin_prime_test_top #(
    parameter int WORD_BITS     = 64,
    parameter int MAX_WITNESSES = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] candidate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        probable_prime
);
    import mrpt_pkg::*;

    logic [CNT_BITS-1:0] count_reg;
    logic [WIT_BITS-1:0] wit_reg [0:6];
    logic [CNT_BITS-1:0] wit_idx;
    dp_cmd_t             cmd;
    logic d_odd, d_zero, d_lsb, red_done, a_zero, mul_done;
    logic x_one, x_pm1, r_one, r_pm1, e_left;
    logic [WORD_BITS-1:0] cand;

    assign cand = candidate[WORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd7;
            for (int i = 0; i < 7; i++)
                wit_reg[i] <= RESET_WITNESS[i];
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WITNESS_COUNT)
                count_reg <= cfg_data[CNT_BITS-1:0];
            else
                wit_reg[cfg_index - 3'd1] <= cfg_data;
        end
    end

    mrpt_ctrl #(.WORD_BITS(WORD_BITS), .MAX_WITNESSES(MAX_WITNESSES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cand(cand),
        .out_valid(out_valid), .out_ready(out_ready), .out_prime(probable_prime),
        .used(count_reg), .wit_idx(wit_idx), .cmd(cmd),
        .d_odd(d_odd), .d_zero(d_zero), .d_lsb(d_lsb), .red_done(red_done),
        .a_zero(a_zero), .mul_done(mul_done), .x_one(x_one), .x_pm1(x_pm1),
        .r_one(r_one), .r_pm1(r_pm1), .e_left(e_left)
    );

    mrpt_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cand(cand),
        .witness(wit_reg[(wit_idx == 3'd7) ? 3'd0 : wit_idx]), .cmd(cmd),
        .d_odd(d_odd), .d_zero(d_zero), .d_lsb(d_lsb), .red_done(red_done),
        .a_zero(a_zero), .mul_done(mul_done), .x_one(x_one), .x_pm1(x_pm1),
        .r_one(r_one), .r_pm1(r_pm1), .e_left(e_left)
    );
endmodule

// ===== rtl/core/mrpt_mulmod.sv =====
// Shift-and-add modular multiply: one bit of b per cycle.
module mrpt_mulmod #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic [WORD_BITS-1:0] m,
    output logic                 busy,
    output logic                 done,
    output logic [WORD_BITS-1:0] result
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] a_reg, m_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   dbl, dsum;
    logic [WORD_BITS-1:0] r1;

    function automatic logic [WORD_BITS-1:0] addm(input logic [WORD_BITS-1:0] x,
                                                    input logic [WORD_BITS-1:0] y,
                                                    input logic [WORD_BITS-1:0] mm);
        logic [WORD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, mm})
            s = s - {1'b0, mm};
        return s[WORD_BITS-1:0];
    endfunction

    always_comb
    begin
        dbl      = '0;
        dsum     = '0;
        r1       = addm(r_reg, r_reg, m_reg);
        r_next   = r_reg;
        b_next   = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            r_next    = '0;
            b_next    = b;
            cnt_next  = CW'(WORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = b_reg[WORD_BITS-1] ? addm(r1, a_reg, m_reg) : r1;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        b_reg <= b_next;
        if (start)
        begin
            a_reg <= a;
            m_reg <= m;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = r_reg;
endmodule

// ===== rtl/core/mrpt_datapath.sv =====
module mrpt_datapath #(
    parameter int WORD_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [WORD_BITS-1:0]          cand,
    input  logic [mrpt_pkg::WIT_BITS-1:0] witness,
    input  mrpt_pkg::dp_cmd_t             cmd,
    output logic                          d_odd,
    output logic                          d_zero,
    output logic                          d_lsb,
    output logic                          red_done,
    output logic                          a_zero,
    output logic                          mul_done,
    output logic                          x_one,
    output logic                          x_pm1,
    output logic                          r_one,
    output logic                          r_pm1,
    output logic                          e_left
);
    import mrpt_pkg::*;

    localparam int EW = $clog2(WORD_BITS + 1);
    localparam int RC = $clog2(WIT_BITS + 1);

    logic [WORD_BITS-1:0] p_reg, pm1_reg, d_reg, dd_reg, f_reg, r_reg, a_reg;
    logic [EW-1:0]        e_reg, k_reg;
    logic [WIT_BITS-1:0]  w_reg;
    logic [RC-1:0]        rc_reg;
    logic [1:0]           sel_reg;
    logic [WORD_BITS:0]   rem2;
    logic                 m_start, m_busy, m_done;
    logic [WORD_BITS-1:0] ma, mb, mres;

    // restoring reduction of the witness, one witness bit per cycle
    assign rem2 = {a_reg, w_reg[WIT_BITS-1]};

    always_comb
    begin
        m_start = (cmd.op == OP_INIT_MUL);
        ma = r_reg;
        mb = f_reg;
        unique case (cmd.mul_sel)
            MUL_RF: begin ma = r_reg; mb = f_reg; end
            MUL_FF: begin ma = f_reg; mb = f_reg; end
            default: begin ma = r_reg; mb = r_reg; end
        endcase
    end

    mrpt_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start),
        .a(ma), .b(mb), .m(p_reg),
        .busy(m_busy), .done(m_done), .result(mres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= MUL_RF;
        else if (m_start)
            sel_reg <= cmd.mul_sel;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                p_reg   <= cand;
                pm1_reg <= cand - 1'b1;
                d_reg   <= cand - 1'b1;
                e_reg   <= '0;
                a_reg   <= '0;
                w_reg   <= witness;
                rc_reg  <= RC'(WIT_BITS);
            end
            OP_SHIFT:
            begin
                d_reg <= d_reg >> 1;
                e_reg <= e_reg + 1'b1;
            end
            OP_REDUCE:
            begin
                if (cmd.start_pow)
                begin
                    a_reg  <= '0;
                    w_reg  <= witness;
                    rc_reg <= RC'(WIT_BITS);
                end
                else if (rc_reg != '0)
                begin
                    if (rem2 >= {1'b0, p_reg})
                        a_reg <= WORD_BITS'(rem2 - {1'b0, p_reg});
                    else
                        a_reg <= rem2[WORD_BITS-1:0];
                    w_reg  <= w_reg << 1;
                    rc_reg <= rc_reg - 1'b1;
                end
            end
            OP_MUL:
            begin
                if (cmd.start_pow)
                begin
                    r_reg  <= WORD_BITS'(1);
                    f_reg  <= a_reg;
                    dd_reg <= d_reg;
                    k_reg  <= EW'(1);
                end
                else if (m_done)
                begin
                    unique case (sel_reg)
                        MUL_RF: r_reg <= mres;
                        MUL_FF:
                        begin
                            f_reg  <= mres;
                            dd_reg <= dd_reg >> 1;
                        end
                        default:
                        begin
                            r_reg <= mres;
                            k_reg <= k_reg + 1'b1;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign d_odd    = d_reg[0];
    assign d_zero   = (dd_reg == '0);
    assign d_lsb    = dd_reg[0];
    assign red_done = (rc_reg == '0);
    assign a_zero   = (a_reg == '0);
    assign mul_done = m_done && !m_busy;
    assign x_one    = (r_reg == WORD_BITS'(1));
    assign x_pm1    = (r_reg == pm1_reg);
    assign r_one    = (mres == WORD_BITS'(1));
    assign r_pm1    = (mres == pm1_reg);
    assign e_left   = (k_reg < e_reg);
endmodule

// ===== rtl/core/mrpt_ctrl.sv =====
module mrpt_ctrl #(
    parameter int WORD_BITS     = 64,
    parameter int MAX_WITNESSES = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [WORD_BITS-1:0]          cand,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_prime,
    input  logic [mrpt_pkg::CNT_BITS-1:0] used,
    output logic [mrpt_pkg::CNT_BITS-1:0] wit_idx,
    output mrpt_pkg::dp_cmd_t             cmd,
    input  logic                          d_odd,
    input  logic                          d_zero,
    input  logic                          d_lsb,
    input  logic                          red_done,
    input  logic                          a_zero,
    input  logic                          mul_done,
    input  logic                          x_one,
    input  logic                          x_pm1,
    input  logic                          r_one,
    input  logic                          r_pm1,
    input  logic                          e_left
);
    import mrpt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SPLIT  = 4'd1;
    localparam logic [3:0] S_WSTART = 4'd2;
    localparam logic [3:0] S_RED    = 4'd3;
    localparam logic [3:0] S_PSTEP  = 4'd5;
    localparam logic [3:0] S_PWAIT  = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_SQ     = 4'd8;
    localparam logic [3:0] S_SQWAIT = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next, lim;
    logic                prime_reg, prime_next;
    logic                res_reg, res_next;   // result item held for the output side
    logic                ov_reg, ov_next;
    logic                sq_reg, sq_next;   // 1: pending mult is f*f
    logic                acc;

    assign lim = (used > CNT_BITS'(MAX_WITNESSES)) ? CNT_BITS'(MAX_WITNESSES) : used;
    assign acc = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        prime_next = prime_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        sq_next    = sq_reg;
        cmd        = '{op: OP_NONE, mul_sel: MUL_RF, start_pow: 1'b0};
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (acc)
                begin
                    cmd.op   = OP_LOAD;
                    idx_next = '0;
                    if (cand < WORD_BITS'(2) || (cand != WORD_BITS'(2) && !cand[0]))
                    begin
                        prime_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (cand == WORD_BITS'(2))
                    begin
                        prime_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        prime_next = 1'b1;
                        state_next = S_SPLIT;
                    end
                end
            S_SPLIT:
                if (d_odd)
                    state_next = S_NEXT;
                else
                    cmd.op = OP_SHIFT;
            S_NEXT:
                if (idx_reg >= lim)
                    state_next = S_DONE;
                else
                begin
                    cmd.op        = OP_REDUCE;
                    cmd.start_pow = 1'b1;
                    state_next    = S_RED;
                end
            S_RED:
            begin
                cmd.op = OP_REDUCE;
                if (red_done)
                    state_next = S_WSTART;
            end
            S_WSTART:
                if (a_zero)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.op        = OP_MUL;
                    cmd.start_pow = 1'b1;
                    state_next    = S_PSTEP;
                end
            S_PSTEP:
                if (d_zero)
                    state_next = S_CHECK;
                else
                begin
                    cmd.op = OP_INIT_MUL;
                    if (d_lsb && !sq_reg)
                    begin
                        cmd.mul_sel = MUL_RF;
                        sq_next     = 1'b1;
                    end
                    else
                    begin
                        cmd.mul_sel = MUL_FF;
                        sq_next     = 1'b0;
                    end
                    state_next = S_PWAIT;
                end
            S_PWAIT:
            begin
                cmd.op = OP_MUL;
                if (mul_done)
                    state_next = S_PSTEP;
            end
            S_CHECK:
                if (x_one || x_pm1)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_NEXT;
                end
                else
                    state_next = S_SQ;
            S_SQ:
                if (!e_left)
                begin
                    prime_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op      = OP_INIT_MUL;
                    cmd.mul_sel = MUL_XX;
                    state_next  = S_SQWAIT;
                end
            S_SQWAIT:
            begin
                cmd.op = OP_MUL;
                if (mul_done)
                begin
                    if (r_pm1)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_NEXT;
                    end
                    else if (r_one)
                    begin
                        prime_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_SQ;
                end
            end
            S_DONE:
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    res_next   = prime_reg;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            prime_reg <= 1'b0;
            res_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            prime_reg <= prime_next;
            res_reg   <= res_next;
            ov_reg    <= ov_next;
            sq_reg    <= (state_reg == S_WSTART) ? 1'b0 : sq_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_prime = res_reg;
    assign wit_idx   = idx_reg;
endmodule
